### src/lnsu_pkg.sv
// Shared types, constants and helper functions for the lattice neighbor step unit.
// Used by every module of the block; depends on nothing else.
package lnsu_pkg;

	localparam int MAX_DIMS          = 10;
	localparam int INDEX_BITS        = 31;
	localparam int MAX_CARPET_LEVELS = 7;
	localparam int SIDE_BITS         = 13;
	localparam int CHOICE_BITS       = 5;

	// Stride value that marks "reaches the index range".
	localparam logic [31:0] STRIDE_SAT = 32'h8000_0000;

	// Configuration register indexes.
	localparam logic [1:0] REG_SIDE = 2'd0;
	localparam logic [1:0] REG_DIMS = 2'd1;
	localparam logic [1:0] REG_WRAP = 2'd2;
	localparam logic [1:0] REG_GEOM = 2'd3;

	// Step status codes.
	localparam logic [1:0] ST_MOVED = 2'd0;
	localparam logic [1:0] ST_EDGE  = 2'd1;
	localparam logic [1:0] ST_HOLE  = 2'd2;

	// Powers of three that open each carpet scale.
	localparam logic [SIDE_BITS-1:0] POW3 [MAX_CARPET_LEVELS] =
		'{13'd3, 13'd9, 13'd27, 13'd81, 13'd243, 13'd729, 13'd2187};

	typedef logic [MAX_DIMS-1:0][SIDE_BITS-1:0] coords_t;

	// Transaction as it moves down the dimension cells.
	typedef struct packed {
		logic [INDEX_BITS-1:0]  site;
		logic [CHOICE_BITS-1:0] choice;
		logic [INDEX_BITS-1:0]  q;
		logic [31:0]            stride;
		coords_t                coords;
		logic [SIDE_BITS-1:0]   sel_digit;
		logic [31:0]            sel_stride;
		logic                   sat_any;
	} dim_item_t;

	// Transaction as it moves down the carpet cells.
	typedef struct packed {
		logic [INDEX_BITS-1:0] target;
		logic [1:0]            status;
		coords_t               coords;
		logic                  sat_any;
		logic                  hole;
	} carpet_item_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] q;
		logic [SIDE_BITS-1:0]  rem;
	} div_res_t;

	// Up to eight restoring division steps, most significant bit first.
	// Quotient bits replace the dividend bits in place.
	function automatic div_res_t div_slice(input logic [INDEX_BITS-1:0] q,
			input logic [SIDE_BITS-1:0] rem, input logic [SIDE_BITS-1:0] l,
			input logic [4:0] top, input logic [3:0] n);
		div_res_t r;
		logic [SIDE_BITS:0] r2;
		logic [4:0] idx;
		r.q = q;
		r.rem = rem;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n) begin
				idx = top - 5'(i);
				r2 = {r.rem, r.q[idx]};
				if (r2 >= {1'b0, l}) begin
					r2 = r2 - {1'b0, l};
					r.q[idx] = 1'b1;
				end else begin
					r.q[idx] = 1'b0;
				end
				r.rem = r2[SIDE_BITS-1:0];
			end
		end
		return r;
	endfunction

	// Exact x / 3 for any 13-bit x, by reciprocal multiplication.
	function automatic logic [SIDE_BITS-1:0] div3(input logic [SIDE_BITS-1:0] x);
		logic [25:0] p;
		p = 26'(x) * 26'd2731;
		return p[25:13];
	endfunction

endpackage

### src/lnsu_dim_cell.sv
// One dimension cell: four stages that divide the running quotient by the side
// length and record this dimension's coordinate and stride. Uses lnsu_pkg.
module lnsu_dim_cell import lnsu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [3:0]           cell_idx,
	input  logic [SIDE_BITS-1:0] side,
	input  logic [3:0]           dims,
	input  logic                 in_vld,
	input  dim_item_t            in_item,
	output logic                 out_vld,
	output dim_item_t            out_item
);

	dim_item_t item_s1, item_s2, item_s3, item_s4;
	dim_item_t n1, n2, n3, n4;
	logic [SIDE_BITS-1:0] rem_s1, rem_s2, rem_s3;
	logic [43:0] prod_s1;
	logic psat_s1;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	div_res_t d1, d2, d3, d4;

	always_comb begin
		d1 = div_slice(in_item.q, '0, side, 5'd30, 4'd8);
		n1 = in_item;
		n1.q = d1.q;
		if (in_item.choice[4:1] == cell_idx)
			n1.sel_stride = in_item.stride;
		if (cell_idx < dims && in_item.stride[31])
			n1.sat_any = 1'b1;

		d2 = div_slice(item_s1.q, rem_s1, side, 5'd22, 4'd8);
		n2 = item_s1;
		n2.q = d2.q;
		// Next stride saturates once it reaches the index range.
		if (psat_s1 || prod_s1 >= 44'(STRIDE_SAT))
			n2.stride = STRIDE_SAT;
		else
			n2.stride = prod_s1[31:0];

		d3 = div_slice(item_s2.q, rem_s2, side, 5'd14, 4'd8);
		n3 = item_s2;
		n3.q = d3.q;

		d4 = div_slice(item_s3.q, rem_s3, side, 5'd6, 4'd7);
		n4 = item_s3;
		n4.q = d4.q;
		n4.coords[cell_idx] = d4.rem;
		if (item_s3.choice[4:1] == cell_idx)
			n4.sel_digit = d4.rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= n1;
			rem_s1  <= d1.rem;
			prod_s1 <= 44'(in_item.stride[30:0]) * 44'(side);
			psat_s1 <= in_item.stride[31];
			item_s2 <= n2;
			rem_s2  <= d2.rem;
			item_s3 <= n3;
			rem_s3  <= d3.rem;
			item_s4 <= n4;
		end
	end

	assign out_vld  = vld_s4;
	assign out_item = item_s4;

endmodule

### src/lnsu_move_unit.sv
// Move unit: decides edge crossing and wrap, forms the target index and the
// target coordinates over two stages. Uses lnsu_pkg.
module lnsu_move_unit import lnsu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [SIDE_BITS-1:0] side,
	input  logic [3:0]           dims,
	input  logic [19:0]          wrap_mask,
	input  logic                 in_vld,
	input  dim_item_t            in_item,
	output logic                 out_vld,
	output carpet_item_t         out_item
);

	dim_item_t item_s1;
	logic [43:0] mult_s1;
	logic plus_s1, edge_s1, blocked_s1, vld_s1, vld_s2;
	carpet_item_t item_s2;

	logic [3:0] dim;
	logic plus, at_edge, wrap, blocked;
	logic [19:0] wrap_bits;
	logic [SIDE_BITS-1:0] side_m1, new_digit;
	dim_item_t n1;
	logic [44:0] target;
	carpet_item_t n2;

	always_comb begin
		dim = in_item.choice[4:1];
		plus = in_item.choice[0];
		side_m1 = side - 13'd1;
		at_edge = plus ? (in_item.sel_digit == side_m1) : (in_item.sel_digit == '0);
		wrap_bits = wrap_mask >> in_item.choice;
		wrap = wrap_bits[0];
		blocked = (dim >= dims) || in_item.sel_stride[31] || (at_edge && !wrap);
		if (plus)
			new_digit = at_edge ? '0 : in_item.sel_digit + 13'd1;
		else
			new_digit = at_edge ? side_m1 : in_item.sel_digit - 13'd1;
		n1 = in_item;
		if (dim < 4'(MAX_DIMS))
			n1.coords[dim] = new_digit;
	end

	always_comb begin
		if (edge_s1)
			target = plus_s1 ? 45'(item_s1.site) - 45'(mult_s1)
			                 : 45'(item_s1.site) + 45'(mult_s1);
		else
			target = plus_s1 ? 45'(item_s1.site) + 45'(item_s1.sel_stride)
			                 : 45'(item_s1.site) - 45'(item_s1.sel_stride);
		n2.target  = target[INDEX_BITS-1:0];
		n2.status  = (blocked_s1 || target >= 45'(STRIDE_SAT)) ? ST_EDGE : ST_MOVED;
		n2.coords  = item_s1.coords;
		n2.sat_any = item_s1.sat_any;
		n2.hole    = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1    <= n1;
			mult_s1    <= 44'(in_item.sel_stride[30:0]) * 44'(side_m1);
			plus_s1    <= plus;
			edge_s1    <= at_edge;
			blocked_s1 <= blocked;
			item_s2    <= n2;
		end
	end

	assign out_vld  = vld_s2;
	assign out_item = item_s2;

endmodule

### src/lnsu_carpet_cell.sv
// One carpet scale cell: tests whether every used coordinate has digit one at
// this base-3 scale, then hands the coordinates on divided by three. Uses lnsu_pkg.
module lnsu_carpet_cell import lnsu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [2:0]           level,
	input  logic [SIDE_BITS-1:0] side,
	input  logic [3:0]           dims,
	input  logic                 in_vld,
	input  carpet_item_t         in_item,
	output logic                 out_vld,
	output carpet_item_t         out_item
);

	carpet_item_t item_s1, n1;
	logic vld_s1;
	logic all_one;
	logic [SIDE_BITS-1:0] q, m;

	always_comb begin
		n1 = in_item;
		all_one = 1'b1;
		for (int c = 0; c < MAX_DIMS; c++) begin
			q = div3(in_item.coords[c]);
			m = in_item.coords[c] - 13'(q * 13'd3);
			if (4'(c) < dims && m != 13'd1)
				all_one = 1'b0;
			n1.coords[c] = q;
		end
		if (POW3[level] <= side && all_one && dims != '0)
			n1.hole = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (adv)
			item_s1 <= n1;
	end

	assign out_vld  = vld_s1;
	assign out_item = item_s1;

endmodule

### src/lattice_neighbor_step_unit.sv
// Top level of the lattice neighbor step unit: configuration registers, the chain
// of dimension cells, the move unit, the chain of carpet cells and the output skid.
// Uses lnsu_pkg, lnsu_dim_cell, lnsu_move_unit and lnsu_carpet_cell.
//
// Usage:
//   The slave stream carries one step request per transaction: the linear site
//   index and the move choice. The master stream returns one result per request,
//   in order: the neighbor index and a status (moved, blocked at an open edge,
//   on an unused dimension or out of the index range, or target in a carpet
//   hole). The configuration port writes side length, dimension count, wrap
//   mask and geometry mode; write it only while no transaction is in flight.
//   From acceptance to the master side a request passes ten dimension cells of
//   four stages each (the side length division runs eight, eight, eight and
//   seven quotient bits), two move stages, seven carpet scale cells and the
//   output register. One transaction is accepted every cycle unless the skid is
//   full. Reset clears every valid flag and loads side 3, two dimensions, no
//   wrap and the plain lattice. When the receiver stalls, the result in flight
//   lands in a skid register; s_tready drops only while that register is full,
//   so the whole pipeline holds without losing or repeating a transaction.
module lattice_neighbor_step_unit import lnsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [30:0] site_index, [35:31] move_choice, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [30:0] next_site, [32:31] step_status, rest zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	logic [12:0] side_q;
	logic [3:0]  dims_q;
	logic [19:0] wrap_q;
	logic        geom_q;

	logic [SIDE_BITS-1:0] eff_side;
	logic [3:0] eff_dims;
	logic adv;

	dim_item_t    dim_item [MAX_DIMS+1];
	logic         dim_vld  [MAX_DIMS+1];
	carpet_item_t cp_item  [MAX_CARPET_LEVELS+1];
	logic         cp_vld   [MAX_CARPET_LEVELS+1];

	logic [39:0] res_data, out_q, skid_q;
	logic out_vld_q, skid_vld_q;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 13'd3;
			dims_q <= 4'd2;
			wrap_q <= '0;
			geom_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIDE: side_q <= cfg_data[12:0];
				REG_DIMS: dims_q <= cfg_data[3:0];
				REG_WRAP: wrap_q <= cfg_data;
				REG_GEOM: geom_q <= cfg_data[0];
			endcase
		end
	end

	// A side of zero behaves as side one; more than ten dimensions as ten.
	assign eff_side = (side_q == '0) ? 13'd1 : side_q;
	assign eff_dims = (dims_q > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : dims_q;

	// The pipeline moves whenever the skid register is free.
	assign adv      = !skid_vld_q;
	assign s_tready = adv;

	always_comb begin
		dim_vld[0] = s_tvalid;
		dim_item[0] = '0;
		dim_item[0].site   = s_tdata[30:0];
		dim_item[0].choice = s_tdata[35:31];
		dim_item[0].q      = s_tdata[30:0];
		dim_item[0].stride = 32'd1;
	end

	for (genvar c = 0; c < MAX_DIMS; c++) begin : g_dim
		lnsu_dim_cell u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv), .cell_idx(4'(c)),
			.side(eff_side), .dims(eff_dims),
			.in_vld(dim_vld[c]), .in_item(dim_item[c]),
			.out_vld(dim_vld[c+1]), .out_item(dim_item[c+1])
		);
	end

	lnsu_move_unit u_move (
		.clk(clk), .arst_n(arst_n), .adv(adv), .side(eff_side), .dims(eff_dims),
		.wrap_mask(wrap_q),
		.in_vld(dim_vld[MAX_DIMS]), .in_item(dim_item[MAX_DIMS]),
		.out_vld(cp_vld[0]), .out_item(cp_item[0])
	);

	for (genvar l = 0; l < MAX_CARPET_LEVELS; l++) begin : g_carpet
		lnsu_carpet_cell u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv), .level(3'(l)),
			.side(eff_side), .dims(eff_dims),
			.in_vld(cp_vld[l]), .in_item(cp_item[l]),
			.out_vld(cp_vld[l+1]), .out_item(cp_item[l+1])
		);
	end

	// Final status: a hole counts only in carpet mode, for a move that is not
	// already blocked, and when every used dimension has a stride in range.
	always_comb begin
		logic [1:0] st;
		st = cp_item[MAX_CARPET_LEVELS].status;
		if (st == ST_MOVED && geom_q && cp_item[MAX_CARPET_LEVELS].hole &&
				!cp_item[MAX_CARPET_LEVELS].sat_any)
			st = ST_HOLE;
		res_data = '0;
		res_data[32:31] = st;
		if (st == ST_MOVED)
			res_data[30:0] = cp_item[MAX_CARPET_LEVELS].target;
	end

	assign take = out_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take)
				skid_vld_q <= 1'b0;
		end else if (cp_vld[MAX_CARPET_LEVELS]) begin
			if (!out_vld_q || take)
				out_vld_q <= 1'b1;
			else
				skid_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take)
				out_q <= skid_q;
		end else if (cp_vld[MAX_CARPET_LEVELS]) begin
			if (!out_vld_q || take)
				out_q <= res_data;
			else
				skid_q <= res_data;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

### tb/sv/lnsu_step_checker.sv
// Checker for the lattice neighbor step unit: watches the request and result
// channels and the configuration port, predicts each result and compares it.
// Depends on lnsu_pkg for register indexes, status codes and widths.
module lnsu_step_checker import lnsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	output int          fail_count,
	output int          pending_steps,
	output int          result_count
);

	typedef struct packed {
		logic [INDEX_BITS-1:0] site;
		logic [1:0]            status;
	} step_result_t;

	localparam logic [63:0] INDEX_RANGE = 64'd1 << INDEX_BITS;

	logic [SIDE_BITS-1:0] side_q;
	logic [3:0]           dims_q;
	logic [19:0]          wrap_q;
	logic                 carpet_q;

	step_result_t expected_steps[$];

	function automatic logic [63:0] side_eff();
		return (side_q == 0) ? 64'd1 : 64'(side_q);
	endfunction

	function automatic logic [63:0] dim_stride(input int d);
		logic [63:0] s;
		s = 1;
		for (int c = 0; c < d; c++) begin
			s = s * side_eff();
			if (s >= INDEX_RANGE) return INDEX_RANGE;
		end
		return s;
	endfunction

	function automatic bit in_carpet_hole(input logic [63:0] site);
		logic [63:0] lside, s, scale;
		logic [63:0] coord[MAX_DIMS];
		int nd, levels;
		bit all_one;
		lside = side_eff();
		nd = (dims_q > MAX_DIMS) ? MAX_DIMS : int'(dims_q);
		levels = 0;
		scale = 3;
		if (nd == 0) return 0;
		for (int c = 0; c < nd; c++) begin
			s = dim_stride(c);
			if (s >= INDEX_RANGE) return 0;
			coord[c] = (site / s) % lside;
		end
		while (levels < MAX_CARPET_LEVELS && scale <= lside) begin
			levels++;
			scale = scale * 3;
		end
		for (int lv = 0; lv < levels; lv++) begin
			all_one = 1;
			for (int c = 0; c < nd; c++)
				if (coord[c] % 3 != 1) all_one = 0;
			if (all_one) return 1;
			for (int c = 0; c < nd; c++) coord[c] = coord[c] / 3;
		end
		return 0;
	endfunction

	function automatic step_result_t predict_step(input logic [INDEX_BITS-1:0] site,
			input logic [CHOICE_BITS-1:0] choice);
		step_result_t r;
		logic [63:0] lside, stride, digit, target;
		int dim, nd;
		bit plus;
		r.site = '0;
		r.status = ST_EDGE;
		dim = int'(choice >> 1);
		plus = choice[0];
		nd = (dims_q > MAX_DIMS) ? MAX_DIMS : int'(dims_q);
		lside = side_eff();
		if (dim >= nd || dim >= MAX_DIMS) return r;
		stride = dim_stride(dim);
		if (stride >= INDEX_RANGE) return r;
		digit = (64'(site) / stride) % lside;
		if (plus ? (digit == lside - 1) : (digit == 0)) begin
			if (!wrap_q[choice]) return r;
			target = plus ? 64'(site) - (lside - 1) * stride
				: 64'(site) + (lside - 1) * stride;
		end else begin
			target = plus ? 64'(site) + stride : 64'(site) - stride;
		end
		if (target >= INDEX_RANGE) return r;
		if (carpet_q && in_carpet_hole(target)) begin
			r.status = ST_HOLE;
			return r;
		end
		r.status = ST_MOVED;
		r.site = target[INDEX_BITS-1:0];
		return r;
	endfunction

	assign pending_steps = expected_steps.size();

	always @(posedge clk or negedge arst_n) begin
		step_result_t want;
		if (!arst_n) begin
			side_q <= 13'd3;
			dims_q <= 4'd2;
			wrap_q <= '0;
			carpet_q <= 1'b0;
			fail_count <= 0;
			result_count <= 0;
			expected_steps.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SIDE: side_q <= cfg_data[SIDE_BITS-1:0];
					REG_DIMS: dims_q <= cfg_data[3:0];
					REG_WRAP: wrap_q <= cfg_data;
					REG_GEOM: carpet_q <= cfg_data[0];
				endcase
			end
			if (s_tvalid && s_tready)
				expected_steps.push_back(predict_step(s_tdata[30:0], s_tdata[35:31]));
			if (m_tvalid && m_tready) begin
				result_count <= result_count + 1;
				if (expected_steps.size() == 0) begin
					$display("%0t: result with nothing expected, got %h", $time, m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_steps.pop_front();
					if (m_tdata[30:0] !== want.site || m_tdata[32:31] !== want.status
							|| m_tdata[39:33] !== '0) begin
						$display("%0t: mismatch, expected site %0d status %0d, got site %0d status %0d (raw %h)",
							$time, want.site, want.status, m_tdata[30:0], m_tdata[32:31], m_tdata);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### tb/sv/tb_lattice_neighbor_step_unit.sv
// Testbench top for the lattice neighbor step unit: clock, reset, request and
// configuration stimulus, receiver stalls, watchdog and verdict.
// Depends on lnsu_pkg, lnsu_step_checker and the block itself.
module tb_lattice_neighbor_step_unit;
	import lnsu_pkg::*;

	// Pipeline depth of the block from request to result.
	localparam int PIPE_LATENCY = 50;
	localparam int IDLE_LIMIT   = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;

	int  fail_count, pending_steps, result_count;
	int  idle_cycles = 0;
	bit  long_hold = 0;
	bit  hold_done = 0;

	// Per-phase lattice shape, used to draw sites that mostly lie in the volume.
	logic [63:0] volume;

	lattice_neighbor_step_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lnsu_step_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_steps(pending_steps),
		.result_count(result_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver stalls on a pattern of its own: stretches of always-ready,
	// stretches of random stalls, and one long hold-off while requests keep coming
	// so that the skid fills and s_tready drops.
	initial begin
		int mode_len;
		int mode;
		@(posedge arst_n);
		forever begin
			if (long_hold && !hold_done) begin
				@(posedge clk);
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_done = 1;
			end
			mode = $urandom_range(0, 2);
			mode_len = $urandom_range(5, 60);
			repeat (mode_len) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Watchdog: counts cycles in which no transaction happens on either stream.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// One configuration write; only issued while the block is drained. The write
	// enable stays high so that writes can follow back to back; the caller lowers it.
	task automatic write_reg(input logic [1:0] idx, input logic [19:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	// Waits until every expected result has arrived, then for the pipeline depth
	// so that nothing is left in flight before registers change.
	task automatic drain_block();
		wait (pending_steps == 0);
		repeat (PIPE_LATENCY + 5) @(posedge clk);
	endtask

	task automatic set_lattice(input int side, input int dims, input logic [19:0] wrap,
			input bit carpet);
		logic [63:0] v;
		drain_block();
		write_reg(REG_SIDE, 20'(side));
		write_reg(REG_DIMS, 20'(dims));
		write_reg(REG_WRAP, wrap);
		write_reg(REG_GEOM, 20'(carpet));
		cfg_we <= 1'b0;
		v = 1;
		for (int i = 0; i < dims && v < (64'd1 << 31); i++) v = v * ((side == 0) ? 1 : side);
		volume = (v > (64'd1 << 31)) ? (64'd1 << 31) : v;
	endtask

	// Offers one request and holds it until the block takes it. The valid stays
	// high from one transaction to the next; the caller lowers it for gaps.
	task automatic send_step(input logic [30:0] site, input logic [4:0] choice);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, choice, site};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic idle_gap(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// A random site: mostly inside the volume, sometimes any 31-bit value so that
	// the bits above the volume are carried along.
	function automatic logic [30:0] pick_site();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		if ($urandom_range(0, 9) == 0) return 31'($urandom());
		return 31'(r % volume);
	endfunction

	function automatic logic [4:0] pick_choice();
		if ($urandom_range(0, 15) == 0) return 5'($urandom_range(20, 31));
		return 5'($urandom_range(0, 19));
	endfunction

	// Random requests in bursts, with a random gap after most of the bursts.
	task automatic random_phase(input int count);
		int burst;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_step(pick_site(), pick_choice());
				sent++;
			end
			if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		volume = 9;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset lattice, 3x3 with open edges, corners and center.
		send_step(31'd0, 5'd0);
		send_step(31'd0, 5'd1);
		send_step(31'd8, 5'd3);
		send_step(31'd4, 5'd2);
		send_step(31'd4, 5'd4);      // dimension out of use
		send_step(31'h7FFF_FFFF, 5'd31);
		send_step(31'h7FFF_FFFF, 5'd1);  // target beyond the index range
		idle_gap(1);

		// Full wrap, carpet on a 27x27 lattice: hole targets and wrap landings.
		set_lattice(27, 2, 20'hFFFFF, 1'b1);
		send_step(31'd0, 5'd0);
		send_step(31'd26, 5'd1);
		send_step(31'd27 * 13 + 12, 5'd1);   // lands in the center hole
		send_step(31'd27 * 4 + 3, 5'd1);     // lands in a smaller-scale hole
		send_step(31'd728, 5'd3);
		send_step(31'd0, 5'd2);
		idle_gap(1);

		// Side zero acts as side one; wrap lands on the same site.
		set_lattice(0, 10, 20'h55555, 1'b0);
		send_step(31'd5, 5'd0);
		send_step(31'd5, 5'd1);
		send_step(31'd0, 5'd19);
		idle_gap(1);

		// Side 4096 with ten dimensions: strides saturate, targets overflow.
		set_lattice(4096, 10, 20'hFFFFF, 1'b1);
		send_step(31'd0, 5'd4);
		send_step(31'd0, 5'd2);
		send_step(31'h7FFF_FFFF, 5'd1);
		send_step(31'h7FFF_F000, 5'd0);
		send_step(31'd4095, 5'd1);
		idle_gap(1);

		// Random phases across settings, extremes included.
		set_lattice(3, 2, 20'h0000F, 1'b1);
		random_phase(150);
		set_lattice(2, 10, 20'hAAAAA, 1'b0);
		random_phase(150);
		set_lattice(9, 3, 20'($urandom()), 1'b1);
		random_phase(150);

		// Long receiver hold-off while the sender keeps offering requests.
		set_lattice(81, 4, 20'($urandom()), 1'b1);
		long_hold = 1;
		random_phase(250);
		wait (hold_done);

		set_lattice(243, 2, 20'hFFFFF, 1'b1);
		random_phase(150);
		set_lattice(2187, 2, 20'($urandom()), 1'b1);
		random_phase(150);
		set_lattice(4096, 1, 20'h00003, 1'b0);
		random_phase(100);
		set_lattice(10, 7, 20'($urandom()), 1'b1);
		random_phase(150);
		set_lattice($urandom_range(2, 4096), $urandom_range(0, 15), 20'($urandom()),
			1'($urandom()));
		random_phase(150);
		set_lattice(5, 15, 20'($urandom()), 1'b1);
		random_phase(100);

		// End of stimulus: let every result arrive, then the pipeline depth.
		drain_block();
		$display("covered %0d results over side lengths 0 to 4096, 0 to 15 dimensions,",
			result_count);
		$display("open and wrapped edges, plain and carpet geometry, with stalls on both sides");
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
